// ===== sv/ftso_pkg.sv =====
// Package for the fixed-time state observer: payload types, register
// indexes, reset values, arithmetic constants and shared helper functions.
// Depends on nothing.
package ftso_pkg;

  localparam int AXES_DEF   = 6;
  localparam int FRAC_DEF   = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_W      = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int MUL_W      = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_VEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_EXP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_EXP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd4;

  localparam logic [27:0] GAIN_POS_RST  = 28'd1048576;
  localparam logic [27:0] GAIN_VEL_RST  = 28'd9830400;
  localparam logic [15:0] LOW_EXP_RST   = 16'd39322;
  localparam logic [17:0] HIGH_EXP_RST  = 18'd78643;
  localparam logic [23:0] TIME_STEP_RST = 24'd167772;

  localparam logic [31:0] LN2_Q32  = 32'hB17217F8;
  localparam logic [63:0] POW_CAP  = 64'h4000_0000_0000_0000;
  localparam logic [19:0] DIV3_MUL = 20'd699051;
  localparam int          DIV3_SH  = 21;
  localparam logic [3:0]  LAST_TERM = 4'd10;

  typedef struct packed {
    logic [2:0]         axis;
    logic signed [31:0] measured;
  } in_t;

  typedef struct packed {
    logic [2:0]         axis_out;
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
    logic signed [31:0] estimation_error;
  } out_t;

  typedef struct packed {
    logic [2:0]  axis;
    logic [31:0] measured;
    logic        ok;
  } job_t;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // floor(2^36 / k) for the series divisors.
  function automatic logic [MUL_W-1:0] recip(input logic [3:0] k);
    logic [MUL_W-1:0] r;
    case (k)
      4'd2:    r = 36'd34359738368;
      4'd3:    r = 36'd22906492245;
      4'd4:    r = 36'd17179869184;
      4'd5:    r = 36'd13743895347;
      4'd6:    r = 36'd11453246122;
      4'd7:    r = 36'd9817068105;
      4'd8:    r = 36'd8589934592;
      4'd9:    r = 36'd7635497415;
      4'd10:   r = 36'd6871947673;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ftso_front.sv =====
// Front stage of the observer: takes input transfers, marks whether the
// axis is in range and hands items to the queue. Depends on ftso_pkg.
module ftso_front import ftso_pkg::*; #(
  parameter int AXES = AXES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  input  logic q_full,
  output logic q_push,
  output job_t q_data
);

  logic hold_r;
  job_t job_r;
  logic take;

  assign in_full = hold_r && q_full;
  assign take    = in_push && !in_full;
  assign q_push  = hold_r && !q_full;
  assign q_data  = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (take) begin
      hold_r <= 1'b1;
    end else if (q_push) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r.axis     <= in_data.axis;
      job_r.measured <= in_data.measured;
      job_r.ok       <= (32'(in_data.axis) < AXES);
    end
  end

endmodule

// ===== sv/ftso_queue.sv =====
// Short queue between the front stage and the update engine.
// Depends on ftso_pkg for the item type.
module ftso_queue import ftso_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== sv/ftso_back.sv =====
// Update engine of the observer: configuration registers, per-axis state,
// a sequencer around one shared multiplier, and the result register.
// Depends on ftso_pkg.
module ftso_back import ftso_pkg::*; #(
  parameter int AXES      = AXES_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_empty,
  input  job_t                 q_head,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_t                 out_data
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_NORM  = 5'd1;
  localparam logic [4:0] S_LOGM  = 5'd2;
  localparam logic [4:0] S_LOGC  = 5'd3;
  localparam logic [4:0] S_PMUL  = 5'd4;
  localparam logic [4:0] S_PFLR  = 5'd5;
  localparam logic [4:0] S_TMUL  = 5'd6;
  localparam logic [4:0] S_TSET  = 5'd7;
  localparam logic [4:0] S_KMUL  = 5'd8;
  localparam logic [4:0] S_KDIV  = 5'd9;
  localparam logic [4:0] S_KFIX  = 5'd10;
  localparam logic [4:0] S_SHIFT = 5'd11;
  localparam logic [4:0] S_KV    = 5'd12;
  localparam logic [4:0] S_KVW   = 5'd13;
  localparam logic [4:0] S_DLO   = 5'd14;
  localparam logic [4:0] S_DHI   = 5'd15;
  localparam logic [4:0] S_DSUM  = 5'd16;
  localparam logic [4:0] S_DV    = 5'd17;
  localparam logic [4:0] S_CLO   = 5'd18;
  localparam logic [4:0] S_CHI   = 5'd19;
  localparam logic [4:0] S_CSUM  = 5'd20;
  localparam logic [4:0] S_CU    = 5'd21;
  localparam logic [4:0] S_XMUL  = 5'd22;
  localparam logic [4:0] S_XUP   = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  logic [4:0]  state_r;
  logic [27:0] g1_r;
  logic [27:0] g2_r;
  logic [15:0] lam_r;
  logic [17:0] phi_r;
  logic [23:0] step_r;
  logic [31:0] pos_r [AXES];
  logic [31:0] vel_r [AXES];

  logic [2:0]    axis_r;
  logic          ok_r;
  logic [31:0]   e_r;
  logic [31:0]   x_r;
  logic [31:0]   v_r;
  logic [31:0]   w_r;
  logic [4:0]    q_r;
  logic [30:0]   y_r;
  logic [15:0]   frac_r;
  logic [3:0]    i_r;
  logic signed [22:0] lg_r;
  logic [17:0]   exp_r [4];
  logic [1:0]    pi_r;
  logic [8:0]    n_r;
  logic [15:0]   f_r;
  logic [31:0]   t_r;
  logic [31:0]   term_r;
  logic [31:0]   p_r;
  logic [3:0]    k_r;
  logic [33:0]   sum_r;
  logic [63:0]   s1_r;
  logic [63:0]   s2_r;
  logic [35:0]   kv_r;
  logic [99:0]   acc_r;
  logic [31:0]   vn_r;
  logic [31:0]   xn_r;
  logic [34:0]   um_r;
  logic          uneg_r;
  logic [71:0]   mul_r;
  logic          out_valid_r;
  out_t          out_r;

  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;

  logic [3:0]         axis_ext;
  logic [AW-1:0]      idx_in;
  logic [AW-1:0]      idx_r;
  logic [31:0]        x_in;
  logic signed [39:0] diff_in;
  logic [31:0]        e_in;
  logic [32:0]        neg_e;
  logic [31:0]        mag_in;
  logic [18:0]        lam3;
  logic [18:0]        phi3;
  logic [38:0]        lam3_q;
  logic [38:0]        phi3_q;
  logic [16:0]        lam1;
  logic [18:0]        phi1;

  logic [31:0]        yy;
  logic signed [6:0]  qmf;
  logic [22:0]        lneg;
  logic [21:0]        lmag;
  logic [23:0]        pabs;
  logic [24:0]        pval;
  logic signed [9:0]  s_sh;
  logic [9:0]         nsh;
  logic [63:0]        wide;
  logic [63:0]        pw;
  logic [31:0]        qa;
  logic [35:0]        qk;
  logic [35:0]        rem;
  logic [31:0]        term_n;
  logic               e_pos;
  logic               e_neg;
  logic [33:0]        dv;
  logic signed [39:0] vsum;
  logic [34:0]        cc;
  logic signed [39:0] usum;
  logic [39:0]        uneg;
  logic [34:0]        dx;
  logic signed [39:0] xw;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  assign axis_ext = {1'b0, q_head.axis};
  assign idx_in   = axis_ext[AW-1:0];
  assign idx_r    = AW'({1'b0, axis_r});
  assign e_pos    = !e_r[31] && (e_r != '0);
  assign e_neg    = e_r[31];

  always_comb begin
    x_in    = pos_r[idx_in];
    diff_in = $signed({{8{q_head.measured[31]}}, q_head.measured}) -
              $signed({{8{x_in[31]}}, x_in});
    e_in    = sat32(diff_in);
    neg_e   = 33'd0 - {e_in[31], e_in};
    mag_in  = e_in[31] ? neg_e[31:0] : e_in;
    lam1    = {1'b0, lam_r} + 17'h10000;
    phi1    = {1'b0, phi_r} + 19'h10000;
    lam3    = {3'b0, lam_r} + 19'h20000;
    phi3    = {1'b0, phi_r} + 19'h20000;
    lam3_q  = (39'(lam3) * 39'(DIV3_MUL)) >> DIV3_SH;
    phi3_q  = (39'(phi3) * 39'(DIV3_MUL)) >> DIV3_SH;
  end

  always_comb begin
    yy   = mul_r[61:30];
    qmf  = $signed({2'b00, q_r}) - $signed(7'(FRAC_BITS));
    lneg = 23'd0 - lg_r;
    lmag = lg_r[22] ? lneg[21:0] : lg_r[21:0];
    pabs = lg_r[22] ? 24'((mul_r[39:0] + 40'd65535) >> 16) : mul_r[39:16];
    pval = lg_r[22] ? (25'd0 - {1'b0, pabs}) : {1'b0, pabs};
    s_sh = $signed({n_r[8], n_r}) + $signed(10'(FRAC_BITS - 32));
    nsh  = 10'd0 - s_sh;
    wide = {30'b0, sum_r} << s_sh[4:0];
    if (s_sh >= 10'sd30) begin
      pw = POW_CAP;
    end else if (s_sh >= 10'sd0) begin
      pw = (wide > POW_CAP) ? POW_CAP : wide;
    end else if (nsh >= 10'd34) begin
      pw = '0;
    end else begin
      pw = {30'b0, sum_r} >> nsh[5:0];
    end
    qa     = mul_r[67:36];
    qk     = 36'(qa) * 36'(k_r);
    rem    = {4'b0, p_r} - qk;
    term_n = (rem >= 36'(k_r)) ? qa + 1'b1 : qa;
    dv     = (|acc_r[99:57]) ? 34'h2_0000_0000 : {1'b0, acc_r[56:24]};
    vsum   = $signed({{8{v_r[31]}}, v_r});
    if (e_pos) begin
      vsum = vsum + $signed({6'b0, dv});
    end else if (e_neg) begin
      vsum = vsum - $signed({6'b0, dv});
    end
    cc   = (|acc_r[99:50]) ? 35'h4_0000_0000 : {1'b0, acc_r[49:16]};
    usum = $signed({{8{vn_r[31]}}, vn_r});
    if (e_pos) begin
      usum = usum + $signed({5'b0, cc});
    end else if (e_neg) begin
      usum = usum - $signed({5'b0, cc});
    end
    uneg = 40'd0 - usum;
    dx   = mul_r[58:24];
    xw   = uneg_r ? ($signed({{8{x_r[31]}}, x_r}) - $signed({5'b0, dx}))
                  : ($signed({{8{x_r[31]}}, x_r}) + $signed({5'b0, dx}));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LOGM: begin
        mul_a = MUL_W'(y_r);
        mul_b = MUL_W'(y_r);
      end
      S_PMUL: begin
        mul_a = MUL_W'(lmag);
        mul_b = MUL_W'(exp_r[pi_r]);
      end
      S_TMUL: begin
        mul_a = MUL_W'(f_r);
        mul_b = MUL_W'(LN2_Q32);
      end
      S_KMUL: begin
        mul_a = MUL_W'(term_r);
        mul_b = MUL_W'(t_r);
      end
      S_KDIV: begin
        mul_a = MUL_W'(mul_r[63:32]);
        mul_b = recip(k_r);
      end
      S_KV: begin
        mul_a = MUL_W'(g2_r);
        mul_b = MUL_W'(step_r);
      end
      S_DLO: begin
        mul_a = MUL_W'(s2_r[31:0]);
        mul_b = kv_r;
      end
      S_DHI: begin
        mul_a = MUL_W'(s2_r[63:32]);
        mul_b = kv_r;
      end
      S_CLO: begin
        mul_a = MUL_W'(s1_r[31:0]);
        mul_b = MUL_W'(g1_r);
      end
      S_CHI: begin
        mul_a = MUL_W'(s1_r[63:32]);
        mul_b = MUL_W'(g1_r);
      end
      S_XMUL: begin
        mul_a = MUL_W'(um_r);
        mul_b = MUL_W'(step_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r   <= GAIN_POS_RST;
      g2_r   <= GAIN_VEL_RST;
      lam_r  <= LOW_EXP_RST;
      phi_r  <= HIGH_EXP_RST;
      step_r <= TIME_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_POS:  g1_r   <= cfg_data[27:0];
        CFG_GAIN_VEL:  g2_r   <= cfg_data[27:0];
        CFG_LOW_EXP:   lam_r  <= cfg_data[15:0];
        CFG_HIGH_EXP:  phi_r  <= cfg_data[17:0];
        CFG_TIME_STEP: step_r <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      if (out_pop && out_valid_r && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            axis_r   <= q_head.axis;
            ok_r     <= q_head.ok;
            x_r      <= x_in;
            v_r      <= vel_r[idx_in];
            exp_r[0] <= 18'(lam1 >> 1);
            exp_r[1] <= 18'(phi1 >> 1);
            exp_r[2] <= lam3_q[17:0];
            exp_r[3] <= phi3_q[17:0];
            s1_r     <= '0;
            s2_r     <= '0;
            pi_r     <= '0;
            w_r      <= mag_in;
            q_r      <= 5'd31;
            if (!q_head.ok) begin
              e_r     <= '0;
              xn_r    <= '0;
              vn_r    <= '0;
              state_r <= S_OUT;
            end else begin
              e_r     <= e_in;
              state_r <= (mag_in == '0) ? S_KV : S_NORM;
            end
          end
        end
        S_NORM: begin
          if (w_r[31]) begin
            y_r     <= w_r[31:1];
            i_r     <= 4'd15;
            frac_r  <= '0;
            state_r <= S_LOGM;
          end else begin
            w_r <= w_r << 1;
            q_r <= q_r - 1'b1;
          end
        end
        S_LOGM: state_r <= S_LOGC;
        S_LOGC: begin
          if (yy[31]) begin
            y_r         <= yy[31:1];
            frac_r[i_r] <= 1'b1;
          end else begin
            y_r <= yy[30:0];
          end
          if (i_r == '0) begin
            lg_r    <= $signed({qmf, frac_r[15:1], yy[31]});
            state_r <= S_PMUL;
          end else begin
            i_r     <= i_r - 1'b1;
            state_r <= S_LOGM;
          end
        end
        S_PMUL: state_r <= S_PFLR;
        S_PFLR: begin
          n_r     <= pval[24:16];
          f_r     <= pval[15:0];
          state_r <= S_TMUL;
        end
        S_TMUL: state_r <= S_TSET;
        S_TSET: begin
          t_r     <= mul_r[47:16];
          term_r  <= mul_r[47:16];
          sum_r   <= 34'h1_0000_0000 + {2'b0, mul_r[47:16]};
          k_r     <= 4'd2;
          state_r <= S_KMUL;
        end
        S_KMUL: state_r <= S_KDIV;
        S_KDIV: begin
          p_r     <= mul_r[63:32];
          state_r <= S_KFIX;
        end
        S_KFIX: begin
          term_r <= term_n;
          sum_r  <= sum_r + {2'b0, term_n};
          if (k_r == LAST_TERM) begin
            state_r <= S_SHIFT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_KMUL;
          end
        end
        S_SHIFT: begin
          if (pi_r[1]) begin
            s1_r <= s1_r + pw;
          end else begin
            s2_r <= s2_r + pw;
          end
          pi_r    <= pi_r + 1'b1;
          state_r <= (pi_r == 2'd3) ? S_KV : S_PMUL;
        end
        S_KV:  state_r <= S_KVW;
        S_KVW: begin
          kv_r    <= mul_r[51:16];
          state_r <= S_DLO;
        end
        S_DLO: state_r <= S_DHI;
        S_DHI: begin
          acc_r   <= 100'(mul_r);
          state_r <= S_DSUM;
        end
        S_DSUM: begin
          acc_r   <= acc_r + {mul_r[67:0], 32'b0};
          state_r <= S_DV;
        end
        S_DV: begin
          vn_r    <= sat32(vsum);
          state_r <= S_CLO;
        end
        S_CLO: state_r <= S_CHI;
        S_CHI: begin
          acc_r   <= 100'(mul_r);
          state_r <= S_CSUM;
        end
        S_CSUM: begin
          acc_r   <= acc_r + {mul_r[67:0], 32'b0};
          state_r <= S_CU;
        end
        S_CU: begin
          uneg_r  <= usum[39];
          um_r    <= usum[39] ? uneg[34:0] : usum[34:0];
          state_r <= S_XMUL;
        end
        S_XMUL: state_r <= S_XUP;
        S_XUP: begin
          xn_r    <= sat32(xw);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r             <= 1'b1;
            out_r.axis_out          <= axis_r;
            out_r.position_estimate <= xn_r;
            out_r.velocity_estimate <= vn_r;
            out_r.estimation_error  <= e_r;
            if (ok_r) begin
              pos_r[idx_r] <= xn_r;
              vel_r[idx_r] <= vn_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/fixed_time_state_observer.sv =====
// Fixed-time state observer: one item per transfer updates the position
// and velocity estimates of its axis if that axis is in range. An item
// with a nonzero error has its magnitude normalized and goes through the
// log and the four powers, an item with zero error skips those steps, and
// an item with an out-of-range axis goes straight to the output. The
// sequencer steps the single shared multiplier through the 16 squaring
// steps of the log, the ten series terms of each of the four powers and
// the final updates. Up to three items wait in the front register and
// queue, and one result waits in the output register while the engine
// goes on. Depends on ftso_pkg, ftso_front, ftso_queue and ftso_back.
module fixed_time_state_observer import ftso_pkg::*; #(
  parameter int AXES      = AXES_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  in_t                  in_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_wdata;
  job_t q_head;

  ftso_front #(.AXES(AXES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  ftso_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ftso_back #(.AXES(AXES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("engine took an item from an empty queue");

  a_full_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_full)
    else $error("input stalled while the queue had room");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown right after reset");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for the fixed-time state observer: directed and random items,
// random idling on both sides, a scoreboard class that predicts each result.
// Depends on ftso_pkg and fixed_time_state_observer.
`timescale 1ns / 1ps

module tb;
  import ftso_pkg::*;

  localparam int N_AXES = 6;
  localparam int STALL_LIMIT = 20000;

  class observer_scoreboard;
    logic [27:0] g1, g2;
    logic [15:0] lam;
    logic [17:0] phi;
    logic [23:0] dt;
    longint pos [N_AXES];
    longint vel [N_AXES];
    out_t pending[$];
    int errors;

    function void reset_state();
      g1 = GAIN_POS_RST;
      g2 = GAIN_VEL_RST;
      lam = LOW_EXP_RST;
      phi = HIGH_EXP_RST;
      dt = TIME_STEP_RST;
      foreach (pos[i]) begin
        pos[i] = 0;
        vel[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
      case (idx)
        CFG_GAIN_POS:  g1 = d[27:0];
        CFG_GAIN_VEL:  g2 = d[27:0];
        CFG_LOW_EXP:   lam = d[15:0];
        CFG_HIGH_EXP:  phi = d[17:0];
        CFG_TIME_STEP: dt = d[23:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function bit [63:0] umul_sat(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = a * b;
      if (p[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return p[63:0];
    endfunction

    function longint floor16(longint v);
      if (v >= 0) return v / 65536;
      return -((-v + 65535) / 65536);
    endfunction

    function longint log2_fix(bit [63:0] m);
      int q;
      bit [63:0] y;
      longint fr;
      q = 31;
      fr = 0;
      while (q > 0 && m[q] == 1'b0) q--;
      if (q <= 30) y = m << (30 - q);
      else y = m >> (q - 30);
      for (int i = 15; i >= 0; i--) begin
        y = (y * y) >> 30;
        if (y >= (64'd2 << 30)) begin
          y = y >> 1;
          fr = fr | (64'sd1 << i);
        end
      end
      return (longint'(q) - FRAC_DEF) * 65536 + fr;
    endfunction

    function bit [63:0] mag_power(bit [63:0] m, bit [63:0] a);
      longint p, n, s;
      bit [63:0] f, t, term, acc;
      if (m == 0) return 0;
      p = floor16(log2_fix(m) * longint'(a));
      n = floor16(p);
      f = p - n * 65536;
      t = (f * 64'hB17217F8) >> 16;
      term = 64'd1 << 32;
      acc = term;
      for (int k = 1; k <= 10; k++) begin
        term = ((term * t) >> 32) / k;
        acc += term;
      end
      s = n + FRAC_DEF - 32;
      if (s >= 30) return POW_CAP;
      if (s >= 0) begin
        acc = acc << s;
        return acc > POW_CAP ? POW_CAP : acc;
      end
      if (s <= -64) return 0;
      return acc >> (-s);
    endfunction

    function void note_input(in_t it);
      out_t r;
      longint e, sg, v, x, u, su;
      bit [63:0] m, s1, s2, kv, dv, c, um, dx;
      r = '0;
      r.axis_out = it.axis;
      if (it.axis < N_AXES) begin
        x = pos[it.axis];
        v = vel[it.axis];
        e = clamp32(longint'(it.measured) - x);
        sg = e > 0 ? 1 : (e < 0 ? -1 : 0);
        m = e < 0 ? -e : e;
        s2 = mag_power(m, (64'(lam) + 65536) >> 1) + mag_power(m, (64'(phi) + 65536) >> 1);
        s1 = mag_power(m, (64'(lam) + 131072) / 3) + mag_power(m, (64'(phi) + 131072) / 3);
        kv = (64'(g2) * 64'(dt)) >> 16;
        dv = umul_sat(s2, kv) >> 24;
        if (dv > (64'd1 << 33)) dv = 64'd1 << 33;
        v = clamp32(v + sg * longint'(dv));
        c = umul_sat(64'(g1), s1) >> 16;
        if (c > (64'd1 << 34)) c = 64'd1 << 34;
        u = v + sg * longint'(c);
        su = u > 0 ? 1 : (u < 0 ? -1 : 0);
        um = u < 0 ? -u : u;
        dx = (um * 64'(dt)) >> 24;
        x = clamp32(x + su * longint'(dx));
        pos[it.axis] = x;
        vel[it.axis] = v;
        r.position_estimate = x[31:0];
        r.velocity_estimate = v[31:0];
        r.estimation_error = e[31:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t w;
      if (pending.size() == 0) begin
        $error("unexpected result transfer axis %0d", got.axis_out);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.axis_out !== w.axis_out) begin
        $error("axis_out expected %0d actual %0d", w.axis_out, got.axis_out);
        errors++;
      end
      if (got.position_estimate !== w.position_estimate) begin
        $error("position_estimate expected %0d actual %0d",
               w.position_estimate, got.position_estimate);
        errors++;
      end
      if (got.velocity_estimate !== w.velocity_estimate) begin
        $error("velocity_estimate expected %0d actual %0d",
               w.velocity_estimate, got.velocity_estimate);
        errors++;
      end
      if (got.estimation_error !== w.estimation_error) begin
        $error("estimation_error expected %0d actual %0d",
               w.estimation_error, got.estimation_error);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_t in_data;
  logic out_empty;
  logic out_pop;
  out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  observer_scoreboard estimates;
  bit steady_pop;
  int idle_cycles;

  fixed_time_state_observer dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (!out_empty && out_pop) estimates.check_result(out_data);
      out_pop <= steady_pop ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (!out_empty && out_pop)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[fixed_time_state_observer] ERROR");
      $finish;
    end
  end

  // The push request stays high between back-to-back items; drain lowers it.
  task automatic push_item(logic [2:0] ax, logic [31:0] meas, bit steady);
    in_t it;
    if (!steady && ($urandom_range(99) < 38)) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    it.axis = ax;
    it.measured = meas;
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    estimates.note_input(it);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (estimates.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // The write enable stays high between back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    estimates.write_reg(idx, d);
  endtask

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  initial begin
    logic [2:0] ax;
    estimates = new();
    estimates.reset_state();
    steady_pop = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(3'd0, 32'h7FFF_FFFF, 0);
    push_item(3'd0, 32'h8000_0000, 0);
    push_item(3'd0, 32'h8000_0000, 0);
    push_item(3'd1, 32'h0000_0000, 0);
    push_item(3'd1, 32'h0001_0000, 0);
    push_item(3'd1, 32'h0001_0000, 0);
    push_item(3'd2, 32'hFFFF_FFFF, 0);
    push_item(3'd3, 32'h0000_0001, 0);
    push_item(3'd4, 32'h5555_5555, 0);
    push_item(3'd5, 32'hAAAA_AAAA, 0);
    push_item(3'd6, 32'h1234_5678, 0);
    push_item(3'd7, 32'hFFFF_FFFF, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_GAIN_POS, 28'h0);
          write_reg(CFG_GAIN_VEL, 28'hFFF_FFFF);
          write_reg(CFG_LOW_EXP, 28'd1);
          write_reg(CFG_HIGH_EXP, 28'd65537);
          write_reg(CFG_TIME_STEP, 28'hFF_FFFF);
        end
        2: begin
          write_reg(CFG_GAIN_POS, 28'hFFF_FFFF);
          write_reg(CFG_GAIN_VEL, 28'h0);
          write_reg(CFG_LOW_EXP, 28'hFFFF);
          write_reg(CFG_HIGH_EXP, 28'h3_FFFF);
          write_reg(CFG_TIME_STEP, 28'd1);
        end
        3: begin
          write_reg(CFG_GAIN_POS, 28'h0);
          write_reg(CFG_HIGH_EXP, 28'h0);
          write_reg(CFG_LOW_EXP, 28'h0);
          write_reg(3'd5, 28'hABC_DEF0);
          write_reg(3'd7, 28'h123_4567);
        end
        4, 5: begin
          write_reg(CFG_GAIN_POS, 28'($urandom));
          write_reg(CFG_GAIN_VEL, 28'($urandom_range(1 << 25)));
          write_reg(CFG_LOW_EXP, 28'($urandom));
          write_reg(CFG_HIGH_EXP, 28'($urandom));
          write_reg(CFG_TIME_STEP, 28'($urandom));
        end
        default: ;
      endcase
      cfg_we <= 1'b0;
      steady_pop = (ph == 2);
      for (int i = 0; i < 250; i++) begin
        ax = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        push_item(ax, rand_meas(), ph == 2);
      end
      drain();
    end

    if (estimates.errors == 0) begin
      $display("[fixed_time_state_observer] OK");
    end else begin
      $display("[fixed_time_state_observer] ERROR");
    end
    $finish;
  end

endmodule
